FILE: rtl/xcfp_pkg.sv
// ----------------------------------------------------------------------------
// xcfp_pkg
// Shared types and constants for the XOR-checked frame parser.
// ----------------------------------------------------------------------------
package xcfp_pkg;

  // payload buffer geometry
  localparam int unsigned BufDepth = 64;
  localparam int unsigned BufAw    = $clog2(BufDepth);

  // field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 7;
  localparam int unsigned IdxW  = 6;

  // reset values of the configuration registers
  localparam logic [ByteW-1:0] StartMarkerRst = 8'hAA;
  localparam logic [LenW-1:0]  MaxPayloadRst  = 7'd64;

  // buffer depth as a length value, used to clamp the configured limit
  localparam logic [LenW-1:0]  BufDepthLen    = LenW'(BufDepth);

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_START_MARKER = 1'b0,
    REG_MAX_PAYLOAD  = 1'b1
  } cfg_reg_e;

  // receive parser phase
  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_TYPE  = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4
  } phase_e;

  // transaction sequencer state
  typedef enum logic [1:0] {
    CTL_IDLE  = 2'd0,
    CTL_FETCH = 2'd1,
    CTL_SEND  = 2'd2
  } ctl_e;

endpackage

FILE: rtl/xor_checked_frame_parser.sv
// Input: every received byte is taken while the block is idle.
// A check byte that matches starts a drain of the payload buffer: each result
// is first read from the buffer, then loaded into the output register, and is
// held there while the output stalls; an empty frame gives its single result
// in the cycle after the check byte. No input is taken during the drain.
// Reset: asynchronous, active low; parser back to hunting, registers to 0xAA/64.
// ----------------------------------------------------------------------------
// xor_checked_frame_parser
// Start-marker / type / length framed byte parser with XOR check byte,
// buffering the payload and replaying it one byte per result transaction.
// ----------------------------------------------------------------------------
module xor_checked_frame_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write port
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  // receive channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  // frame channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_type_o,
  output logic [6:0] frame_length_o,
  output logic [7:0] payload_byte_o,
  output logic [5:0] byte_index_o,
  output logic       has_payload_o,
  output logic       last_byte_o
);

  // configuration registers
  logic [xcfp_pkg::ByteW-1:0] start_marker_q;
  logic [xcfp_pkg::LenW-1:0]  max_payload_q;

  // parser state
  xcfp_pkg::phase_e           phase_q, phase_d;
  logic [xcfp_pkg::ByteW-1:0] held_type_q, held_type_d;
  logic [xcfp_pkg::LenW-1:0]  held_length_q, held_length_d;
  logic [xcfp_pkg::LenW-1:0]  fill_index_q, fill_index_d;
  logic [xcfp_pkg::ByteW-1:0] running_xor_q, running_xor_d;

  // sequencer and output register
  xcfp_pkg::ctl_e             ctl_q, ctl_d;
  logic [xcfp_pkg::LenW-1:0]  drain_idx_q, drain_idx_d;
  logic                       out_valid_q, out_valid_d;
  logic [xcfp_pkg::ByteW-1:0] payload_byte_q, payload_byte_d;
  logic [xcfp_pkg::IdxW-1:0]  byte_index_q, byte_index_d;
  logic                       has_payload_q, has_payload_d;
  logic                       last_byte_q, last_byte_d;

  // buffer ports
  logic                       buf_we;
  logic                       buf_re;
  logic [xcfp_pkg::BufAw-1:0] buf_raddr;
  logic [xcfp_pkg::ByteW-1:0] buf_rdata;

  logic                       in_acc;
  logic                       out_acc;
  logic [xcfp_pkg::LenW-1:0]  len_limit;
  logic [xcfp_pkg::LenW-1:0]  fill_next;
  logic [xcfp_pkg::LenW-1:0]  drain_next;

  // input is only taken while no drain is running
  assign in_stall_o = (ctl_q != xcfp_pkg::CTL_IDLE);

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;

  // effective length limit
  assign len_limit = (max_payload_q > xcfp_pkg::BufDepthLen) ? xcfp_pkg::BufDepthLen
                                                             : max_payload_q;
  assign fill_next  = fill_index_q + 7'd1;
  assign drain_next = drain_idx_q + 7'd1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= xcfp_pkg::StartMarkerRst;
      max_payload_q  <= xcfp_pkg::MaxPayloadRst;
    end else if (cfg_we_i) begin
      case (xcfp_pkg::cfg_reg_e'(cfg_idx_i))
        xcfp_pkg::REG_START_MARKER: start_marker_q <= cfg_wdata_i;
        xcfp_pkg::REG_MAX_PAYLOAD:  max_payload_q  <= cfg_wdata_i[xcfp_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // payload buffer
  xcfp_ram #(
    .Width (xcfp_pkg::ByteW),
    .Depth (xcfp_pkg::BufDepth)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (fill_index_q[xcfp_pkg::BufAw-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (buf_re),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= xcfp_pkg::PH_HUNT;
      held_type_q   <= '0;
      held_length_q <= '0;
      fill_index_q  <= '0;
      running_xor_q <= '0;
      ctl_q         <= xcfp_pkg::CTL_IDLE;
      drain_idx_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      held_type_q   <= held_type_d;
      held_length_q <= held_length_d;
      fill_index_q  <= fill_index_d;
      running_xor_q <= running_xor_d;
      ctl_q         <= ctl_d;
      drain_idx_q   <= drain_idx_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    payload_byte_q <= payload_byte_d;
    byte_index_q   <= byte_index_d;
    has_payload_q  <= has_payload_d;
    last_byte_q    <= last_byte_d;
  end

  // parser and drain sequencer
  always_comb begin
    phase_d        = phase_q;
    held_type_d    = held_type_q;
    held_length_d  = held_length_q;
    fill_index_d   = fill_index_q;
    running_xor_d  = running_xor_q;
    ctl_d          = ctl_q;
    drain_idx_d    = drain_idx_q;
    out_valid_d    = out_valid_q;
    payload_byte_d = payload_byte_q;
    byte_index_d   = byte_index_q;
    has_payload_d  = has_payload_q;
    last_byte_d    = last_byte_q;
    buf_we         = 1'b0;
    buf_re         = 1'b0;
    buf_raddr      = drain_next[xcfp_pkg::BufAw-1:0];

    case (ctl_q)
      xcfp_pkg::CTL_IDLE: begin
        if (in_acc) begin
          case (phase_q)
            xcfp_pkg::PH_TYPE: begin
              held_type_d   = rx_byte_i;
              running_xor_d = rx_byte_i;
              phase_d       = xcfp_pkg::PH_LEN;
            end
            xcfp_pkg::PH_LEN: begin
              if (rx_byte_i > {1'b0, len_limit}) begin
                phase_d = xcfp_pkg::PH_HUNT;
              end else begin
                held_length_d = rx_byte_i[xcfp_pkg::LenW-1:0];
                running_xor_d = running_xor_q ^ rx_byte_i;
                fill_index_d  = '0;
                phase_d       = (rx_byte_i == 8'd0) ? xcfp_pkg::PH_CHECK
                                                    : xcfp_pkg::PH_DATA;
              end
            end
            xcfp_pkg::PH_DATA: begin
              buf_we        = 1'b1;
              running_xor_d = running_xor_q ^ rx_byte_i;
              fill_index_d  = fill_next;
              if (fill_next >= held_length_q) begin
                phase_d = xcfp_pkg::PH_CHECK;
              end
            end
            xcfp_pkg::PH_CHECK: begin
              phase_d = xcfp_pkg::PH_HUNT;
              if (rx_byte_i == running_xor_q) begin
                if (held_length_q == '0) begin
                  // empty frame: single result straight away
                  payload_byte_d = '0;
                  byte_index_d   = '0;
                  has_payload_d  = 1'b0;
                  last_byte_d    = 1'b1;
                  out_valid_d    = 1'b1;
                  ctl_d          = xcfp_pkg::CTL_SEND;
                end else begin
                  // start the drain at entry zero
                  buf_re      = 1'b1;
                  buf_raddr   = '0;
                  drain_idx_d = '0;
                  ctl_d       = xcfp_pkg::CTL_FETCH;
                end
              end
            end
            default: begin
              phase_d = (rx_byte_i == start_marker_q) ? xcfp_pkg::PH_TYPE
                                                      : xcfp_pkg::PH_HUNT;
            end
          endcase
        end
      end
      xcfp_pkg::CTL_FETCH: begin
        // buffer data now available, load the output register
        payload_byte_d = buf_rdata;
        byte_index_d   = drain_idx_q[xcfp_pkg::IdxW-1:0];
        has_payload_d  = 1'b1;
        last_byte_d    = (drain_next == held_length_q);
        out_valid_d    = 1'b1;
        ctl_d          = xcfp_pkg::CTL_SEND;
      end
      xcfp_pkg::CTL_SEND: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          if (last_byte_q) begin
            ctl_d = xcfp_pkg::CTL_IDLE;
          end else begin
            buf_re      = 1'b1;
            drain_idx_d = drain_next;
            ctl_d       = xcfp_pkg::CTL_FETCH;
          end
        end
      end
      default: begin
        ctl_d       = xcfp_pkg::CTL_IDLE;
        out_valid_d = 1'b0;
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign frame_type_o   = held_type_q;
  assign frame_length_o = held_length_q;
  assign payload_byte_o = payload_byte_q;
  assign byte_index_o   = byte_index_q;
  assign has_payload_o  = has_payload_q;
  assign last_byte_o    = last_byte_q;

endmodule

FILE: rtl/xcfp_ram.sv
// ----------------------------------------------------------------------------
// xcfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module xcfp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
